// ===== rtl/swsr_pkg.sv =====
package swsr_pkg;

    // Register widths and reset values
    localparam int START_WIDTH   = 20;
    localparam int TIMEOUT_WIDTH = 16;
    localparam int THRESH_WIDTH  = 16;
    localparam int CFG_DATA_WIDTH = 20;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [START_WIDTH-1:0]   START_LOW_RESET = 20'd20000;
    localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET   = 16'd254;
    localparam logic [THRESH_WIDTH-1:0]  THRESH_RESET    = 16'd31;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_LOW = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TIMEOUT   = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THRESH    = 2'd2;

    // Frame layout
    localparam int FRAME_BITS = 40;
    localparam int INDEX_WIDTH = 6;
    localparam logic [INDEX_WIDTH-1:0] TOTAL_BITS = 6'd40;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_RESP1 = 3'd2,
        PH_RESP2 = 3'd3,
        PH_RESP3 = 3'd4,
        PH_BITLO = 3'd5,
        PH_BITHI = 3'd6
    } phase_t;

    typedef struct packed {
        logic [START_WIDTH-1:0]   start_low_ticks;
        logic [TIMEOUT_WIDTH-1:0] response_timeout_ticks;
        logic [THRESH_WIDTH-1:0]  one_threshold_ticks;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       data_valid;
        logic       retry_pulse;
        logic [7:0] humidity_whole;
        logic [7:0] humidity_fraction;
        logic [7:0] temperature_whole;
        logic [7:0] temperature_fraction;
        logic [7:0] checksum_byte;
    } result_t;

endpackage

// ===== rtl/single_wire_sensor_reader_unit.sv =====
// Single-wire temperature and humidity sensor reader.
// Input channel: one word per sample tick of the data wire, carrying the
// sampled line_level and action (1 requests a read when idle). Output
// channel: one result word per input word, giving drive_low for the wire
// driver, busy_res, the data_valid and retry_pulse strobes, and the five
// bytes of the last completed read (zero until the first read finishes).
// Result words are registered in the output buffer. Throughput: one word
// per clock while in_stall is low; the reader state updates in a single
// pass between the state registers and the output register.
// A two-word output buffer lets input continue while a result waits;
// in_stall rises only when both buffer entries are occupied, so a stalled
// receiver holds back the input after one extra word.
// Configuration: cfg_we writes register cfg_index (0 start low ticks,
// 1 response timeout, 2 one threshold) with cfg_data; write only while
// idle. Reset returns the reader to idle, clears the bytes and loads the
// default register values (20000, 254, 31).
module single_wire_sensor_reader_unit #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 action,
    input  logic                                 line_level,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 drive_low,
    output logic                                 busy_res,
    output logic                                 data_valid,
    output logic                                 retry_pulse,
    output logic [7:0]                           humidity_whole,
    output logic [7:0]                           humidity_fraction,
    output logic [7:0]                           temperature_whole,
    output logic [7:0]                           temperature_fraction,
    output logic [7:0]                           checksum_byte,
    input  logic                                 cfg_we,
    input  logic [swsr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [swsr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import swsr_pkg::*;

    cfg_t    cfg;
    result_t core_word;
    result_t out_word;
    logic    buf_full;
    logic    accept;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    swsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swsr_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (action),
        .line_level (line_level),
        .cfg        (cfg),
        .result     (core_word)
    );

    swsr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (core_word),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // Unpack the result word onto the ports
    assign drive_low            = out_word.drive_low;
    assign busy_res             = out_word.busy_res;
    assign data_valid           = out_word.data_valid;
    assign retry_pulse          = out_word.retry_pulse;
    assign humidity_whole       = out_word.humidity_whole;
    assign humidity_fraction    = out_word.humidity_fraction;
    assign temperature_whole    = out_word.temperature_whole;
    assign temperature_fraction = out_word.temperature_fraction;
    assign checksum_byte        = out_word.checksum_byte;

endmodule

// ===== rtl/swsr_cfg.sv =====
module swsr_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [swsr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [swsr_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output swsr_pkg::cfg_t                      cfg
);
    import swsr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START_LOW: cfg_next.start_low_ticks = cfg_data[START_WIDTH-1:0];
                CFG_TIMEOUT:   cfg_next.response_timeout_ticks = cfg_data[TIMEOUT_WIDTH-1:0];
                CFG_THRESH:    cfg_next.one_threshold_ticks = cfg_data[THRESH_WIDTH-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks        <= START_LOW_RESET;
            cfg_reg.response_timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.one_threshold_ticks    <= THRESH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/swsr_core.sv =====
module swsr_core #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              action,
    input  logic              line_level,
    input  swsr_pkg::cfg_t    cfg,
    output swsr_pkg::result_t result
);
    import swsr_pkg::*;

    localparam int TW = (COUNTER_WIDTH > START_WIDTH) ? COUNTER_WIDTH : START_WIDTH;
    localparam logic [TW-1:0] SAT_TOP = TW'((64'd1 << COUNTER_WIDTH) - 64'd1);
    localparam logic [TW-1:0] ONE = TW'(1);

    phase_t                 phase_reg, phase_next;
    logic [TW-1:0]          tick_reg, tick_next;
    logic [INDEX_WIDTH-1:0] index_reg, index_next;
    logic [FRAME_BITS-1:0]  bits_reg, bits_next;
    logic [FRAME_BITS-1:0]  shown_reg, shown_next;

    logic [TW-1:0]          tick_sat;
    logic [TW-1:0]          start_len;
    logic [TW-1:0]          timeout_len;
    logic [TW-1:0]          thresh_len;
    logic                   enter_to;
    logic                   timeout;
    logic                   valid;
    logic                   bit_val;

    // Widen the registers to the tick width TW (COUNTER_WIDTH or START_WIDTH, the larger)
    assign start_len   = TW'(cfg.start_low_ticks);
    assign timeout_len = TW'(cfg.response_timeout_ticks);
    assign thresh_len  = TW'(cfg.one_threshold_ticks);
    assign tick_sat    = (tick_reg >= SAT_TOP) ? SAT_TOP : tick_reg + ONE;
    assign enter_to    = (ONE >= timeout_len);
    assign bit_val     = (tick_reg > thresh_len);

    // Advance the reader state by one sample
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        index_next = index_reg;
        bits_next  = bits_reg;
        shown_next = shown_reg;
        timeout    = 1'b0;
        valid      = 1'b0;
        unique case (phase_reg)
            PH_START:
            begin
                if (tick_reg >= start_len)
                begin
                    phase_next = PH_RESP1;
                    tick_next  = '0;
                end
                else
                begin
                    tick_next = tick_reg + ONE;
                end
            end
            PH_RESP1:
            begin
                if (line_level)
                begin
                    tick_next = tick_sat;
                    timeout   = (tick_sat >= timeout_len);
                end
                else
                begin
                    phase_next = PH_RESP2;
                    tick_next  = ONE;
                    timeout    = enter_to;
                end
            end
            PH_RESP2:
            begin
                if (!line_level)
                begin
                    tick_next = tick_sat;
                    timeout   = (tick_sat >= timeout_len);
                end
                else
                begin
                    phase_next = PH_RESP3;
                    tick_next  = ONE;
                    timeout    = enter_to;
                end
            end
            PH_RESP3:
            begin
                if (line_level)
                begin
                    tick_next = tick_sat;
                    timeout   = (tick_sat >= timeout_len);
                end
                else
                begin
                    phase_next = PH_BITLO;
                    tick_next  = '0;
                end
            end
            PH_BITLO:
            begin
                if (line_level)
                begin
                    phase_next = PH_BITHI;
                    tick_next  = ONE;
                end
            end
            PH_BITHI:
            begin
                if (line_level)
                begin
                    tick_next = tick_sat;
                end
                else
                begin
                    bits_next  = {bits_reg[FRAME_BITS-2:0], bit_val};
                    index_next = index_reg + INDEX_WIDTH'(1);
                    tick_next  = '0;
                    if (index_next >= TOTAL_BITS)
                    begin
                        shown_next = bits_next;
                        valid      = 1'b1;
                        phase_next = PH_IDLE;
                        index_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_BITLO;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (action)
                begin
                    bits_next  = '0;
                    index_next = '0;
                    phase_next = PH_START;
                    tick_next  = ONE;
                end
            end
        endcase
        // Restart the start pulse on a response timeout
        if (timeout)
        begin
            phase_next = PH_START;
            tick_next  = ONE;
        end
    end

    // Form the result word from the updated state
    always_comb
    begin
        result.drive_low            = (phase_next == PH_START);
        result.busy_res             = (phase_next != PH_IDLE);
        result.data_valid           = valid;
        result.retry_pulse          = timeout;
        result.humidity_whole       = shown_next[39:32];
        result.humidity_fraction    = shown_next[31:24];
        result.temperature_whole    = shown_next[23:16];
        result.temperature_fraction = shown_next[15:8];
        result.checksum_byte        = shown_next[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            index_reg <= '0;
            bits_reg  <= '0;
            shown_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            index_reg <= index_next;
            bits_reg  <= bits_next;
            shown_reg <= shown_next;
        end
    end

endmodule

// ===== rtl/swsr_obuf.sv =====
module swsr_obuf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  swsr_pkg::result_t push_word,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output swsr_pkg::result_t out_word
);
    import swsr_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop = main_valid_reg && !out_stall;

    // Load pushed words into the output or skid register, and move words from the skid to the output register
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_word;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_word;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold payload without reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_word  = main_reg;

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swsr_pkg::*;

    localparam int CNT_WIDTH = 16;
    localparam logic [31:0] CNT_TOP = (32'd1 << CNT_WIDTH) - 32'd1;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    // One directed step: either a register write or a sample tick
    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [CFG_DATA_WIDTH-1:0]  reg_val;
        logic                       act;
        logic                       lvl;
        logic                       known;
        result_t                    want;
    } dir_row_t;

    // One register setting of the random part
    typedef struct packed {
        logic [START_WIDTH-1:0]   start_val;
        logic [TIMEOUT_WIDTH-1:0] tmo_val;
        logic [THRESH_WIDTH-1:0]  thr_val;
        logic [7:0]               frames;
        logic [7:0]               noise;
        logic                     starts_ok;
        logic                     settle;
    } setting_t;

    localparam result_t QUIET_WORD = '0;
    localparam result_t DRIVE_WORD = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam result_t BUSY_WORD  = '{1'b0, 1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    localparam result_t RETRY_WORD = '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

    localparam int DIR_ROWS = 22;
    localparam dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        // idle after reset
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b1, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b0, 1'b1, QUIET_WORD},
        // short start, tight timeout, low threshold
        '{ROW_WRITE, CFG_START_LOW, 20'd1, 1'b0, 1'b0, 1'b0, QUIET_WORD},
        '{ROW_WRITE, CFG_TIMEOUT,   20'd2, 1'b0, 1'b0, 1'b0, QUIET_WORD},
        '{ROW_WRITE, CFG_THRESH,    20'd1, 1'b0, 1'b0, 1'b0, QUIET_WORD},
        // start, then a request while busy that must be ignored
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b1, 1'b1, 1'b1, DRIVE_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b1, 1'b0, 1'b1, BUSY_WORD},
        // first response phase runs into the timeout
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b1, RETRY_WORD},
        // restarted handshake, then the first bits
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b0, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b0, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b0, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b0, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b0, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b1, 1'b0, QUIET_WORD},
        '{ROW_TICK,  CFG_START_LOW, 20'd0, 1'b0, 1'b0, 1'b0, QUIET_WORD}
    };

    localparam int PLAN_LEN = 9;
    localparam setting_t plan [0:PLAN_LEN-1] = '{
        '{20'd20000,   16'd254,   16'd31,    8'd0, 8'd10,  1'b0, 1'b1},
        '{20'd3,       16'd12,    16'd3,     8'd2, 8'd20,  1'b1, 1'b1},
        '{20'd0,       16'd10,    16'd0,     8'd1, 8'd20,  1'b1, 1'b1},
        '{20'd1,       16'd65535, 16'd1,     8'd1, 8'd20,  1'b1, 1'b1},
        '{20'd70,      16'd30,    16'd4,     8'd1, 8'd10,  1'b0, 1'b1},
        '{20'd4,       16'd65535, 16'd65535, 8'd1, 8'd10,  1'b0, 1'b1},
        '{20'd1048575, 16'd20,    16'd5,     8'd0, 8'd40,  1'b0, 1'b1},
        '{20'd6,       16'd8,     16'd2,     8'd1, 8'd20,  1'b1, 1'b1},
        // a timeout of one never lets the reader finish, so this runs last
        '{20'd2,       16'd1,     16'd3,     8'd0, 8'd60,  1'b1, 1'b0}
    };

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       action;
    logic                       line_level;
    logic                       out_valid;
    logic                       out_stall;
    logic                       drive_low;
    logic                       busy_res;
    logic                       data_valid;
    logic                       retry_pulse;
    logic [7:0]                 humidity_whole;
    logic [7:0]                 humidity_fraction;
    logic [7:0]                 temperature_whole;
    logic [7:0]                 temperature_fraction;
    logic [7:0]                 checksum_byte;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    // Reader state mirrored by the predictor
    cfg_t                       reader_cfg;
    phase_t                     rd_phase;
    logic [31:0]                rd_cnt;
    logic [INDEX_WIDTH-1:0]     rd_idx;
    logic [FRAME_BITS-1:0]      rd_bits;
    logic [FRAME_BITS-1:0]      rd_shown;

    result_t                    words_due [$];
    int                         mismatch_count = 0;
    int                         words_checked = 0;
    int                         item_seq = 0;

    single_wire_sensor_reader_unit #(
        .COUNTER_WIDTH(CNT_WIDTH)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_stall             (in_stall),
        .action               (action),
        .line_level           (line_level),
        .out_valid            (out_valid),
        .out_stall            (out_stall),
        .drive_low            (drive_low),
        .busy_res             (busy_res),
        .data_valid           (data_valid),
        .retry_pulse          (retry_pulse),
        .humidity_whole       (humidity_whole),
        .humidity_fraction    (humidity_fraction),
        .temperature_whole    (temperature_whole),
        .temperature_fraction (temperature_fraction),
        .checksum_byte        (checksum_byte),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 100)
        begin
            $display("ERROR %0t: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want)
        begin
            flag_mismatch($sformatf("word %0d %s: got %0h, expected %0h",
                                    words_checked, name, got, want));
        end
    endtask

    task automatic reset_reader();
        reader_cfg.start_low_ticks        = START_LOW_RESET;
        reader_cfg.response_timeout_ticks = TIMEOUT_RESET;
        reader_cfg.one_threshold_ticks    = THRESH_RESET;
        rd_phase = PH_IDLE;
        rd_cnt   = '0;
        rd_idx   = '0;
        rd_bits  = '0;
        rd_shown = '0;
    endtask

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v >= CNT_TOP) ? CNT_TOP : v + 32'd1;
    endfunction

    // Advance the reader by one sample tick and form its result word
    task automatic step_reader(input logic req, input logic lvl, output result_t word);
        logic done;
        logic tmo;
        logic bitv;
        done = 1'b0;
        tmo  = 1'b0;
        case (rd_phase)
            PH_START:
            begin
                if (rd_cnt >= {12'd0, reader_cfg.start_low_ticks})
                begin
                    rd_phase = PH_RESP1;
                    rd_cnt   = '0;
                end
                else
                begin
                    rd_cnt = rd_cnt + 32'd1;
                end
            end
            PH_RESP1, PH_RESP3:
            begin
                if (lvl)
                begin
                    rd_cnt = sat_inc(rd_cnt);
                    tmo = rd_cnt >= {16'd0, reader_cfg.response_timeout_ticks};
                end
                else if (rd_phase == PH_RESP1)
                begin
                    rd_phase = PH_RESP2;
                    rd_cnt   = 32'd1;
                    tmo = rd_cnt >= {16'd0, reader_cfg.response_timeout_ticks};
                end
                else
                begin
                    rd_phase = PH_BITLO;
                    rd_cnt   = '0;
                end
            end
            PH_RESP2:
            begin
                if (!lvl)
                begin
                    rd_cnt = sat_inc(rd_cnt);
                end
                else
                begin
                    rd_phase = PH_RESP3;
                    rd_cnt   = 32'd1;
                end
                tmo = rd_cnt >= {16'd0, reader_cfg.response_timeout_ticks};
            end
            PH_BITLO:
            begin
                if (lvl)
                begin
                    rd_phase = PH_BITHI;
                    rd_cnt   = 32'd1;
                end
            end
            PH_BITHI:
            begin
                if (lvl)
                begin
                    rd_cnt = sat_inc(rd_cnt);
                end
                else
                begin
                    bitv    = rd_cnt > {16'd0, reader_cfg.one_threshold_ticks};
                    rd_bits = {rd_bits[FRAME_BITS-2:0], bitv};
                    rd_idx  = rd_idx + INDEX_WIDTH'(1);
                    rd_cnt  = '0;
                    if (rd_idx >= TOTAL_BITS)
                    begin
                        rd_shown = rd_bits;
                        done     = 1'b1;
                        rd_phase = PH_IDLE;
                        rd_idx   = '0;
                    end
                    else
                    begin
                        rd_phase = PH_BITLO;
                    end
                end
            end
            default:
            begin
                rd_phase = PH_IDLE;
                if (req)
                begin
                    rd_bits  = '0;
                    rd_idx   = '0;
                    rd_phase = PH_START;
                    rd_cnt   = 32'd1;
                end
            end
        endcase
        // a timed-out response phase restarts the start signal
        if (tmo)
        begin
            rd_phase = PH_START;
            rd_cnt   = 32'd1;
        end
        word = '{rd_phase == PH_START, rd_phase != PH_IDLE, done, tmo,
                 rd_shown[39:32], rd_shown[31:24], rd_shown[23:16],
                 rd_shown[15:8], rd_shown[7:0]};
    endtask

    function automatic int pick_gap();
        int roll;
        // leave every fourth stretch of 200 words without gaps
        if ((item_seq / 200) % 4 == 3)
        begin
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 70)
        begin
            return 0;
        end
        if (roll < 97)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Offer one sample word, hold it until taken, then predict its result
    task automatic send_word(input logic a, input logic l, input logic known,
                             input result_t want);
        int      gap;
        result_t next;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= a;
        line_level <= l;
        do
            @(posedge clk);
        while (in_stall);
        step_reader(a, l, next);
        words_due.push_back(known ? want : next);
        item_seq++;
    endtask

    task automatic send_run(input logic lvl, input int n, input logic stray);
        int i;
        for (i = 0; i < n; i++)
        begin
            send_word(stray && ($urandom_range(0, 15) == 0), lvl, 1'b0, QUIET_WORD);
        end
    endtask

    task automatic send_noise(input int n, input logic starts_ok);
        int i;
        for (i = 0; i < n; i++)
        begin
            send_word(starts_ok && ($urandom_range(0, 5) == 0), 1'($urandom_range(0, 1)),
                      1'b0, QUIET_WORD);
        end
    endtask

    function automatic int resp_len();
        int t;
        t = int'(reader_cfg.response_timeout_ticks);
        if (t <= 1)
        begin
            return 1;
        end
        // now and then overstay the phase to force a retry
        if (t <= 300 && reader_cfg.start_low_ticks < 1000 && $urandom_range(0, 9) == 0)
        begin
            return t + $urandom_range(0, 2);
        end
        return $urandom_range(1, (t - 1 < 8) ? t - 1 : 8);
    endfunction

    function automatic int pulse_len();
        int h;
        h = int'(reader_cfg.one_threshold_ticks);
        // with a huge threshold keep the pulses short, all decoding as zero
        if (h > 1000)
        begin
            return $urandom_range(1, 3);
        end
        if ($urandom_range(0, 1) == 1)
        begin
            return h + 1 + $urandom_range(0, 2);
        end
        return $urandom_range((h > 3) ? h - 2 : 1, (h == 0) ? 1 : h);
    endfunction

    // Play one sensor transaction, sometimes cut short
    task automatic send_frame();
        int n;
        int cut;
        int k;
        n   = (reader_cfg.start_low_ticks == 0) ? 1 : int'(reader_cfg.start_low_ticks);
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 39) : FRAME_BITS;
        send_word(1'b1, 1'($urandom_range(0, 1)), 1'b0, QUIET_WORD);
        send_run(1'b0, n, 1'b1);
        send_run(1'b1, resp_len(), 1'b1);
        send_run(1'b0, resp_len(), 1'b1);
        send_run(1'b1, resp_len(), 1'b1);
        for (k = 0; k < cut; k++)
        begin
            send_run(1'b0, $urandom_range(1, 3), 1'b1);
            send_run(1'b1, pulse_len(), 1'b1);
        end
        send_run(1'b0, $urandom_range(1, 2), 1'b1);
        send_run(1'b1, $urandom_range(0, 4), 1'b0);
    endtask

    // Walk the reader back to idle with the level each phase waits for
    task automatic settle_reader();
        while (rd_phase != PH_IDLE)
        begin
            case (rd_phase)
                PH_RESP1, PH_RESP3, PH_BITHI: send_word(1'b0, 1'b0, 1'b0, QUIET_WORD);
                default:                      send_word(1'b0, 1'b1, 1'b0, QUIET_WORD);
            endcase
        end
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (words_due.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        drain_words();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_START_LOW: reader_cfg.start_low_ticks        = val[START_WIDTH-1:0];
            CFG_TIMEOUT:   reader_cfg.response_timeout_ticks = val[TIMEOUT_WIDTH-1:0];
            CFG_THRESH:    reader_cfg.one_threshold_ticks    = val[THRESH_WIDTH-1:0];
            default:       ;
        endcase
    endtask

    // Stimulus
    initial
    begin
        int       r;
        int       p;
        int       f;
        dir_row_t row;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = 1'b0;
        line_level = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_START_LOW;
        cfg_data   = '0;
        reset_reader();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed steps
        for (r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_rows[r];
            if (row.kind == ROW_WRITE)
            begin
                write_reg(row.reg_idx, row.reg_val);
            end
            else
            begin
                send_word(row.act, row.lvl, row.known, row.want);
            end
        end
        settle_reader();

        // random transactions under each setting
        for (p = 0; p < PLAN_LEN; p++)
        begin
            write_reg(CFG_START_LOW, plan[p].start_val);
            write_reg(CFG_TIMEOUT, {4'd0, plan[p].tmo_val});
            write_reg(CFG_THRESH, {4'd0, plan[p].thr_val});
            for (f = 0; f < plan[p].frames; f++)
            begin
                send_frame();
            end
            send_noise(plan[p].noise, plan[p].starts_ok);
            if (plan[p].settle)
            begin
                settle_reader();
            end
        end

        drain_words();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Compare one taken result word against the oldest prediction
    task automatic check_word();
        result_t want;
        if (words_due.size() == 0)
        begin
            flag_mismatch($sformatf("word %0d arrived with none predicted", words_checked));
        end
        else
        begin
            want = words_due.pop_front();
            compare_field("drive_low", {7'd0, drive_low}, {7'd0, want.drive_low});
            compare_field("busy_res", {7'd0, busy_res}, {7'd0, want.busy_res});
            compare_field("data_valid", {7'd0, data_valid}, {7'd0, want.data_valid});
            compare_field("retry_pulse", {7'd0, retry_pulse}, {7'd0, want.retry_pulse});
            compare_field("humidity_whole", humidity_whole, want.humidity_whole);
            compare_field("humidity_fraction", humidity_fraction, want.humidity_fraction);
            compare_field("temperature_whole", temperature_whole, want.temperature_whole);
            compare_field("temperature_fraction", temperature_fraction,
                          want.temperature_fraction);
            compare_field("checksum_byte", checksum_byte, want.checksum_byte);
        end
        words_checked++;
    endtask

    // Receiver: take words, stall at random, and once hold off long
    initial
    begin
        int   stall_left;
        int   cycle_no;
        int   roll;
        logic held;
        stall_left = 0;
        cycle_no   = 0;
        held       = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (out_valid && !out_stall)
            begin
                check_word();
            end
            if (stall_left == 0 && !held && words_checked >= 500)
            begin
                held       = 1'b1;
                stall_left = 300;
            end
            else if (stall_left == 0 && (cycle_no / 300) % 4 != 0)
            begin
                roll = $urandom_range(0, 99);
                if (roll >= 97)
                begin
                    stall_left = $urandom_range(8, 30);
                end
                else if (roll >= 72)
                begin
                    stall_left = $urandom_range(1, 3);
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog
    initial
    begin
        #100ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/swsr_pkg.sv
rtl/swsr_cfg.sv
rtl/swsr_core.sv
rtl/swsr_obuf.sv
rtl/single_wire_sensor_reader_unit.sv
tb/sv/tb.sv
